[sv/pse_pkg.sv]
// pse_pkg: shared types, constants and functions of the PNG stored-deflate encoder.
// No dependencies; used by pse_front, pse_queue, pse_back and the top level.
package pse_pkg;

    localparam int DIM_W           = 15;
    localparam int MAX_DIMENSION   = 16384;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

    // stored block size is fixed at 65535 bytes; the block count divider relies on it
    localparam logic [15:0] BLOCK_BYTES = 16'hFFFF;
    localparam logic [16:0] ADLER_MOD   = 17'd65521;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RGBA   = 2'd2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [5:0] HDR_LAST      = 6'd42;
    localparam logic [5:0] HDR_CRC_FIRST = 6'd12;
    localparam logic [5:0] HDR_CRC_END   = 6'd28;
    localparam logic [5:0] IDAT_FIRST    = 6'd37;
    localparam logic [5:0] TAIL_LAST     = 6'd19;
    localparam logic [5:0] IEND_FIRST    = 6'd12;
    localparam logic [5:0] IEND_END      = 6'd15;
    localparam logic [5:0] ADLER_END     = 6'd3;

    typedef struct packed {
        logic                cmd;
        logic [31:0]         pixel;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DIV, ST_LEN, ST_HDR, ST_DATA, ST_TAIL
    } state_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = (x >> 1) ^ (x[0] ? 32'hEDB88320 : 32'd0);
        end
        return x;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIMENSION)) begin
            r = DIM_W'(MAX_DIMENSION);
        end
        return r;
    endfunction

endpackage

[sv/pse_queue.sv]
// pse_queue: short register FIFO of classified items between front and back.
// Depends on pse_pkg (entry_t, QUEUE_DEPTH).
module pse_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  pse_pkg::entry_t  push_data,
    input  logic             pop,
    output logic             full,
    output logic             valid,
    output pse_pkg::entry_t  data
);
    pse_pkg::entry_t                  mem_reg [pse_pkg::QUEUE_DEPTH];
    logic [pse_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [pse_pkg::QUEUE_PTR_W:0]    count_reg, count_next;

    assign full  = (count_reg == (pse_pkg::QUEUE_PTR_W+1)'(pse_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !(pop && valid)) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop && valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && valid) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

[sv/pse_front.sv]
// pse_front: configuration registers, input acceptance and item classification.
// Depends on pse_pkg (entry_t, register codes, clamp_dim).
module pse_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [pse_pkg::DIM_W-1:0]     cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [31:0]                   s_pixel,
    input  logic                          q_full,
    output logic                          q_push,
    output pse_pkg::entry_t               q_data
);
    logic [pse_pkg::DIM_W-1:0] width_reg, height_reg;
    logic                      rgba_reg;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_data.cmd    = s_cmd;
        // BGRA input: swap bytes 0 and 2
        q_data.pixel  = rgba_reg ? s_pixel
                                 : {s_pixel[31:24], s_pixel[7:0], s_pixel[15:8], s_pixel[23:16]};
        q_data.width  = pse_pkg::clamp_dim(width_reg);
        q_data.height = pse_pkg::clamp_dim(height_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= pse_pkg::DIM_W'(1);
            height_reg <= pse_pkg::DIM_W'(1);
            rgba_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pse_pkg::REG_WIDTH:  width_reg  <= cfg_wr_data;
                pse_pkg::REG_HEIGHT: height_reg <= cfg_wr_data;
                pse_pkg::REG_RGBA:   rgba_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end
endmodule

[sv/pse_back.sv]
// pse_back: byte sequencer; headers, stored blocks, Adler-32, CRC-32, trailer.
// Depends on pse_pkg (entry_t, state_t, crc_byte, constants).
module pse_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  pse_pkg::entry_t   q_data,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_run_last,
    output logic              m_file_last
);
    pse_pkg::state_t state_reg, state_next;

    logic [5:0]   idx_reg, idx_next;
    logic         open_reg, open_next;
    logic [14:0]  w_reg, w_next, h_reg, h_next;
    logic [13:0]  col_reg, col_next, row_reg, row_next;
    logic [15:0]  blk_reg, blk_next;
    logic [30:0]  strm_reg, strm_next;
    logic [31:0]  crc_reg, crc_next;
    logic [15:0]  alo_reg, alo_next, ahi_reg, ahi_next;
    logic [30:0]  filt_reg, filt_next;
    logic [15:0]  nq_reg, nq_next;
    logic [16:0]  rem_reg, rem_next;
    logic [31:0]  len_reg, len_next;
    logic [31:0]  pix_reg, pix_next;
    logic         fin_reg, fin_next;
    logic [2:0]   slot_reg, slot_next, bh_reg, bh_next;
    logic         mv_reg, mv_next;
    logic [7:0]   mb_reg, mb_next;
    logic         mrl_reg, mrl_next, mfl_reg, mfl_next;

    logic         advance, emit, crc_en, rl, fl;
    logic [7:0]   ob, dbyte;
    logic [31:0]  crc_base, crc_fin, product;
    logic [15:0]  bsize, binv, blocks;
    logic [16:0]  asum, hsum;

    assign advance     = !mv_reg || m_ready;
    assign m_valid     = mv_reg;
    assign m_out_byte  = mb_reg;
    assign m_run_last  = mrl_reg;
    assign m_file_last = mfl_reg;
    assign crc_fin     = ~crc_reg;
    assign product     = 32'(h_reg) * 32'({w_reg, 2'b01});
    assign blocks      = nq_reg + 16'(rem_reg != '0);
    assign bsize       = (strm_reg < 31'(pse_pkg::BLOCK_BYTES)) ? strm_reg[15:0]
                                                                 : pse_pkg::BLOCK_BYTES;
    assign binv        = ~bsize;

    always_comb begin
        case (slot_reg)
            3'd1:    dbyte = pix_reg[7:0];
            3'd2:    dbyte = pix_reg[15:8];
            3'd3:    dbyte = pix_reg[23:16];
            3'd4:    dbyte = pix_reg[31:24];
            default: dbyte = 8'd0;   // filter byte
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pse_pkg::ST_IDLE: begin
                if (advance && q_valid) begin
                    if (q_data.cmd == pse_pkg::CMD_START) begin
                        state_next = pse_pkg::ST_MUL;
                    end else if (open_reg) begin
                        state_next = pse_pkg::ST_DATA;
                    end
                end
            end
            pse_pkg::ST_MUL: state_next = pse_pkg::ST_DIV;
            pse_pkg::ST_DIV: state_next = pse_pkg::ST_LEN;
            pse_pkg::ST_LEN: begin
                if (rem_reg < 17'(pse_pkg::BLOCK_BYTES)) begin
                    state_next = pse_pkg::ST_HDR;
                end
            end
            pse_pkg::ST_HDR: begin
                if (advance && idx_reg == pse_pkg::HDR_LAST) begin
                    state_next = pse_pkg::ST_IDLE;
                end
            end
            pse_pkg::ST_DATA: begin
                if (advance && blk_reg != '0 && slot_reg == 3'd4) begin
                    state_next = fin_reg ? pse_pkg::ST_TAIL : pse_pkg::ST_IDLE;
                end
            end
            pse_pkg::ST_TAIL: begin
                if (advance && idx_reg == pse_pkg::TAIL_LAST) begin
                    state_next = pse_pkg::ST_IDLE;
                end
            end
            default: state_next = pse_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        idx_next = idx_reg;   open_next = open_reg;  w_next = w_reg;    h_next = h_reg;
        col_next = col_reg;   row_next = row_reg;    blk_next = blk_reg;
        strm_next = strm_reg; alo_next = alo_reg;    ahi_next = ahi_reg;
        filt_next = filt_reg; nq_next = nq_reg;      rem_next = rem_reg;
        len_next = len_reg;   pix_next = pix_reg;    fin_next = fin_reg;
        slot_next = slot_reg; bh_next = bh_reg;
        emit = 1'b0; ob = 8'd0; rl = 1'b0; fl = 1'b0; crc_en = 1'b0;
        crc_base = crc_reg; q_pop = 1'b0;
        asum = 17'(alo_reg) + 17'(dbyte);
        if (asum >= pse_pkg::ADLER_MOD) asum = asum - pse_pkg::ADLER_MOD;
        hsum = 17'(ahi_reg) + asum;
        if (hsum >= pse_pkg::ADLER_MOD) hsum = hsum - pse_pkg::ADLER_MOD;

        case (state_reg)
            pse_pkg::ST_IDLE: begin
                if (advance && q_valid) begin
                    q_pop = 1'b1;
                    if (q_data.cmd == pse_pkg::CMD_START) begin
                        w_next = q_data.width;
                        h_next = q_data.height;
                    end else if (open_reg) begin
                        pix_next  = q_data.pixel;
                        slot_next = (col_reg == '0) ? 3'd0 : 3'd1;
                        fin_next  = (15'(col_reg) + 15'd1 >= w_reg)
                                 && (15'(row_reg) + 15'd1 >= h_reg);
                    end
                end
            end
            pse_pkg::ST_MUL: filt_next = product[30:0];
            pse_pkg::ST_DIV: begin
                // x / 65535: x = q*65536 + r  ->  q + (r + q) / 65535
                nq_next  = 16'(filt_reg[30:16]);
                rem_next = 17'(filt_reg[15:0]) + 17'(filt_reg[30:16]);
            end
            pse_pkg::ST_LEN: begin
                if (rem_reg >= 17'(pse_pkg::BLOCK_BYTES)) begin
                    nq_next  = nq_reg + 16'd1;
                    rem_next = rem_reg - 17'(pse_pkg::BLOCK_BYTES);
                end else begin
                    len_next  = 32'(filt_reg) + 32'(blocks) * 32'd5 + 32'd6;
                    open_next = 1'b1;
                    col_next  = '0;
                    row_next  = '0;
                    blk_next  = '0;
                    bh_next   = '0;
                    strm_next = filt_reg;
                    alo_next  = 16'd1;
                    ahi_next  = 16'd0;
                    idx_next  = '0;
                end
            end
            pse_pkg::ST_HDR: begin
                if (advance) begin
                    emit = 1'b1;
                    case (idx_reg)
                        6'd0:  ob = 8'd137;
                        6'd1:  ob = 8'd80;
                        6'd2:  ob = 8'd78;
                        6'd3:  ob = 8'd71;
                        6'd4:  ob = 8'd13;
                        6'd5:  ob = 8'd10;
                        6'd6:  ob = 8'd26;
                        6'd7:  ob = 8'd10;
                        6'd11: ob = 8'd13;
                        6'd12: ob = 8'd73;   // I
                        6'd13: ob = 8'd72;   // H
                        6'd14: ob = 8'd68;   // D
                        6'd15: ob = 8'd82;   // R
                        6'd18: ob = {1'b0, w_reg[14:8]};
                        6'd19: ob = w_reg[7:0];
                        6'd22: ob = {1'b0, h_reg[14:8]};
                        6'd23: ob = h_reg[7:0];
                        6'd24: ob = 8'd8;
                        6'd25: ob = 8'd6;
                        6'd29: ob = crc_fin[31:24];
                        6'd30: ob = crc_fin[23:16];
                        6'd31: ob = crc_fin[15:8];
                        6'd32: ob = crc_fin[7:0];
                        6'd33: ob = len_reg[31:24];
                        6'd34: ob = len_reg[23:16];
                        6'd35: ob = len_reg[15:8];
                        6'd36: ob = len_reg[7:0];
                        6'd37: ob = 8'd73;   // I
                        6'd38: ob = 8'd68;   // D
                        6'd39: ob = 8'd65;   // A
                        6'd40: ob = 8'd84;   // T
                        6'd41: ob = 8'h78;
                        6'd42: ob = 8'h01;
                        default: ob = 8'd0;
                    endcase
                    crc_en = (idx_reg >= pse_pkg::HDR_CRC_FIRST && idx_reg <= pse_pkg::HDR_CRC_END)
                          || (idx_reg >= pse_pkg::IDAT_FIRST);
                    if (idx_reg == pse_pkg::HDR_CRC_FIRST || idx_reg == pse_pkg::IDAT_FIRST) begin
                        crc_base = 32'hFFFFFFFF;
                    end
                    rl = (idx_reg == pse_pkg::HDR_LAST);
                    idx_next = idx_reg + 6'd1;
                end
            end
            pse_pkg::ST_DATA: begin
                if (advance) begin
                    emit   = 1'b1;
                    crc_en = 1'b1;
                    if (blk_reg == '0) begin
                        // stored block header: BFINAL, LEN, NLEN
                        case (bh_reg)
                            3'd0:    ob = {7'd0, (31'(bsize) == strm_reg)};
                            3'd1:    ob = bsize[7:0];
                            3'd2:    ob = bsize[15:8];
                            3'd3:    ob = binv[7:0];
                            default: ob = binv[15:8];
                        endcase
                        bh_next = bh_reg + 3'd1;
                        if (bh_reg == 3'd4) begin
                            bh_next  = '0;
                            blk_next = bsize;
                        end
                    end else begin
                        ob        = dbyte;
                        alo_next  = asum[15:0];
                        ahi_next  = hsum[15:0];
                        blk_next  = blk_reg - 16'd1;
                        strm_next = strm_reg - 31'd1;
                        slot_next = slot_reg + 3'd1;
                        if (slot_reg == 3'd4) begin
                            if (15'(col_reg) + 15'd1 >= w_reg) begin
                                col_next = '0;
                                row_next = row_reg + 14'd1;
                            end else begin
                                col_next = col_reg + 14'd1;
                            end
                            idx_next = '0;
                            rl = !fin_reg;
                        end
                    end
                end
            end
            pse_pkg::ST_TAIL: begin
                if (advance) begin
                    emit = 1'b1;
                    case (idx_reg)
                        6'd0:  ob = ahi_reg[15:8];
                        6'd1:  ob = ahi_reg[7:0];
                        6'd2:  ob = alo_reg[15:8];
                        6'd3:  ob = alo_reg[7:0];
                        6'd4:  ob = crc_fin[31:24];
                        6'd5:  ob = crc_fin[23:16];
                        6'd6:  ob = crc_fin[15:8];
                        6'd7:  ob = crc_fin[7:0];
                        6'd12: ob = 8'd73;   // I
                        6'd13: ob = 8'd69;   // E
                        6'd14: ob = 8'd78;   // N
                        6'd15: ob = 8'd68;   // D
                        6'd16: ob = crc_fin[31:24];
                        6'd17: ob = crc_fin[23:16];
                        6'd18: ob = crc_fin[15:8];
                        6'd19: ob = crc_fin[7:0];
                        default: ob = 8'd0;
                    endcase
                    crc_en = (idx_reg <= pse_pkg::ADLER_END)
                          || (idx_reg >= pse_pkg::IEND_FIRST && idx_reg <= pse_pkg::IEND_END);
                    if (idx_reg == pse_pkg::IEND_FIRST) begin
                        crc_base = 32'hFFFFFFFF;
                    end
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg == pse_pkg::TAIL_LAST) begin
                        rl = 1'b1;
                        fl = 1'b1;
                        open_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        crc_next = crc_en ? pse_pkg::crc_byte(crc_base, ob) : crc_reg;
        mv_next  = advance ? emit : mv_reg;
        mb_next  = advance ? ob   : mb_reg;
        mrl_next = advance ? rl   : mrl_reg;
        mfl_next = advance ? fl   : mfl_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pse_pkg::ST_IDLE;
            open_reg  <= 1'b0;
            mv_reg    <= 1'b0;
            col_reg   <= '0;
            row_reg   <= '0;
            blk_reg   <= '0;
            bh_reg    <= '0;
            strm_reg  <= '0;
            crc_reg   <= 32'hFFFFFFFF;
            alo_reg   <= 16'd1;
            ahi_reg   <= 16'd0;
            w_reg     <= 15'd1;
            h_reg     <= 15'd1;
            idx_reg   <= '0;
            slot_reg  <= '0;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            open_reg  <= open_next;
            mv_reg    <= mv_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            blk_reg   <= blk_next;
            bh_reg    <= bh_next;
            strm_reg  <= strm_next;
            crc_reg   <= crc_next;
            alo_reg   <= alo_next;
            ahi_reg   <= ahi_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            idx_reg   <= idx_next;
            slot_reg  <= slot_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        filt_reg <= filt_next;
        nq_reg   <= nq_next;
        rem_reg  <= rem_next;
        len_reg  <= len_next;
        pix_reg  <= pix_next;
        mb_reg   <= mb_next;
        mrl_reg  <= mrl_next;
        mfl_reg  <= mfl_next;
    end
endmodule

[sv/png_stored_deflate_encoder_unit.sv]
// PNG stored-deflate encoder: top level joining front, queue and back.
// Depends on pse_pkg, pse_front, pse_queue, pse_back.
//
// Usage:
//  - Config port: cfg_wr_en/cfg_index/cfg_wr_data write image width (0), height (1)
//    and the RGBA/BGRA flag (2); write only while the block is idle.
//    Width and height are clamped to 1..16384 and captured at each start beat.
//  - Input channel s_*: s_cmd 0 starts an image, 1 carries one pixel in s_pixel.
//    A two-entry queue decouples acceptance from byte generation.
//  - Output channel m_*: one PNG byte per beat; m_run_last marks the last byte of
//    an input beat, m_file_last the final byte of the file.
//  - Throughput: one byte per cycle while the receiver takes them, apart from the
//    length setup after a start beat (multiplier plus block-count divider with its
//    correction step) and the dispatch of each item from the queue. A start beat
//    gives 43 header bytes. A pixel gives 4 bytes, plus one filter byte at row start,
//    plus 5 per stored block header, plus 20 trailer bytes on the last pixel.
//  - Path: an accepted beat is stored in the queue, taken by the sequencer and its
//    bytes leave through the output register; a start beat first runs length setup.
//  - Stall: when m_ready is low the output register holds; the sequencer freezes,
//    the queue fills and then s_ready drops.
//  - Reset (aresetn low, synchronous) empties the queue, closes any image and
//    restores register defaults 1, 1, RGBA. Pixels with no open image give no bytes.
module png_stored_deflate_encoder_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [14:0]  cfg_wr_data,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_cmd,
    input  logic [31:0]  s_pixel,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_out_byte,
    output logic         m_run_last,
    output logic         m_file_last
);
    pse_pkg::entry_t push_data, head_data;
    logic            push, pop, q_full, q_valid;

    pse_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_pixel     (s_pixel),
        .q_full      (q_full),
        .q_push      (push),
        .q_data      (push_data)
    );

    pse_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .valid     (q_valid),
        .data      (head_data)
    );

    pse_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_data      (head_data),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_last  (m_run_last),
        .m_file_last (m_file_last)
    );
endmodule

[sv/pse_checker.sv]
// pse_checker: port-level assertions for the encoder, bound to the top level.
// Depends on png_stored_deflate_encoder_unit port names only.
module pse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_run_last,
    input logic        m_file_last
);
    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_run_last))
        else $error("output beat changed while stalled");

    // end of file is always end of a run
    a_file_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_file_last |-> m_run_last)
        else $error("file_last without run_last");

    // file ends with IEND CRC low byte (0x82)
    a_iend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_file_last |-> m_out_byte == 8'h82)
        else $error("wrong final byte");

    // reset clears the output register
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");
endmodule

bind png_stored_deflate_encoder_unit pse_checker u_pse_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_byte  (m_out_byte),
    .m_run_last  (m_run_last),
    .m_file_last (m_file_last)
);
